// ===== hw/rtl/pfts_pkg.sv =====
`timescale 1ns / 1ps

package pfts_pkg;

    localparam int NUM_FLOWS   = 16;
    localparam int QUEUE_DEPTH = 64;
    localparam int FLOW_W      = $clog2(NUM_FLOWS);
    localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QIDX_W + 1;
    localparam int QMEM_W      = FLOW_W + QIDX_W;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 32;
    localparam int DIV_STEPS   = 48;

    localparam logic [2:0] CMD_PACKET     = 3'd0;
    localparam logic [2:0] CMD_RESUME     = 3'd1;
    localparam logic [2:0] CMD_ACTIVATE   = 3'd2;
    localparam logic [2:0] CMD_MODIFY     = 3'd3;
    localparam logic [2:0] CMD_DEACTIVATE = 3'd4;
    localparam logic [2:0] CMD_CLEAR_CNT  = 3'd5;

    localparam logic [2:0] ACT_PASS     = 3'd0;
    localparam logic [2:0] ACT_SENT     = 3'd1;
    localparam logic [2:0] ACT_QUEUED   = 3'd2;
    localparam logic [2:0] ACT_DROPPED  = 3'd3;
    localparam logic [2:0] ACT_RELEASED = 3'd4;
    localparam logic [2:0] ACT_NONE     = 3'd5;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_UNKNOWN = 2'd1;
    localparam logic [1:0] ST_EMPTY   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_LIMIT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_RATE    = 1'd1;

    typedef struct packed {
        logic [2:0]  command;
        logic [3:0]  flow;
        logic [15:0] size_bytes;
        logic [47:0] now;
        logic [31:0] rate;
        logic [31:0] burst;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  action;
        logic        wake_valid;
        logic [47:0] wake_delay;
        logic [1:0]  status;
        logic [31:0] received_count;
        logic [31:0] sent_count;
        logic [31:0] shaped_count;
        logic [31:0] dropped_count;
    } out_item_t;

    // controller -> datapath
    typedef struct packed {
        logic load;       // latch input beat, read flow entry
        logic mul_go;     // register low half of refill product
        logic mul_acc;    // add high half of refill product
        logic refill;     // apply refill
        logic decide;     // apply command decision
        logic head_read;  // fetch next head after release
        logic div_go;     // start wake delay division
        logic div_step;   // one quotient bit
        logic finish;     // build result
    } ctl_t;

    // datapath -> controller
    typedef struct packed {
        logic need_refill;
        logic need_div;
        logic need_head;
        logic div_done;
    } sts_t;

endpackage

// ===== hw/rtl/per_flow_token_bucket_shaper.sv =====
`timescale 1ns / 1ps

// Per-flow token-bucket shaper for 16 flows, each with a 64-entry queue of
// packet sizes. One command beat is taken at a time. It passes the read,
// decide, head-read and output steps; a refill multiply and a refill step
// come before the decision when the bucket is refilled (a packet on an
// active flow with an empty queue, or a resume with a queued head), and the
// 48-step one-bit-per-cycle divider runs before the output when a wake delay
// is divided. The next command is accepted in the cycle after the result
// beat is formed, even while that result still waits for the output ready;
// a second result only waits if the first is still held.
module per_flow_token_bucket_shaper
    import pfts_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_item_t             out_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    ctl_t ctl;
    sts_t sts;
    logic idle;
    logic out_valid_reg;

    // hold a finished beat until taken
    assign out_valid = out_valid_reg;
    assign in_ready  = idle;

    pfts_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_valid && idle),
        .out_busy (out_valid_reg && !out_ready),
        .sts      (sts),
        .ctl      (ctl),
        .idle     (idle)
    );

    pfts_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .in_item  (in_data),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .sts      (sts),
        .res      (out_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ctl.finish)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

endmodule

// ===== hw/rtl/pfts_ctrl.sv =====
`timescale 1ns / 1ps

module pfts_ctrl
    import pfts_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_fire,
    input  logic out_busy,
    input  sts_t sts,
    output ctl_t ctl,
    output logic idle
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_READ  = 4'd1;
    localparam logic [3:0] S_MUL   = 4'd2;
    localparam logic [3:0] S_FILL  = 4'd3;
    localparam logic [3:0] S_DEC   = 4'd4;
    localparam logic [3:0] S_HEAD  = 4'd5;
    localparam logic [3:0] S_DIVGO = 4'd6;
    localparam logic [3:0] S_DIV   = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;
    localparam logic [3:0] S_MUL2  = 4'd9;

    logic [3:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        ctl = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    ctl.load = 1'b1;
                    state_next = S_READ;
                end
            end
            S_READ:  state_next = sts.need_refill ? S_MUL : S_DEC;
            S_MUL:
            begin
                ctl.mul_go = 1'b1;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                ctl.mul_acc = 1'b1;
                state_next = S_FILL;
            end
            S_FILL:
            begin
                ctl.refill = 1'b1;
                state_next = S_DEC;
            end
            S_DEC:
            begin
                ctl.decide = 1'b1;
                state_next = S_HEAD;
            end
            S_HEAD:
            begin
                ctl.head_read = 1'b1;
                state_next = S_DIVGO;
            end
            S_DIVGO:
            begin
                if (sts.need_div)
                begin
                    ctl.div_go = 1'b1;
                    state_next = S_DIV;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_DIV:
            begin
                ctl.div_step = 1'b1;
                if (sts.div_done)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_busy)
                begin
                    ctl.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign idle = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ===== hw/rtl/pfts_datapath.sv =====
`timescale 1ns / 1ps

module pfts_datapath
    import pfts_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  ctl_t                  ctl,
    input  in_item_t              in_item,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output sts_t                  sts,
    output out_item_t             res
);

    // flow table
    logic [NUM_FLOWS-1:0] exists_reg, active_reg;
    logic [31:0] rate_mem [NUM_FLOWS];
    logic [31:0] burst_mem [NUM_FLOWS];
    logic [31:0] tok_mem [NUM_FLOWS];
    logic [47:0] last_mem [NUM_FLOWS];
    logic [QCNT_W-1:0] qcnt_reg [NUM_FLOWS];
    logic [QIDX_W-1:0] qhead_reg [NUM_FLOWS];
    logic [15:0] qmem [NUM_FLOWS*QUEUE_DEPTH];

    logic [6:0]  qlimit_reg;
    logic [31:0] minrate_reg;
    logic [31:0] cnt_reg [4];

    in_item_t    it_reg;
    logic        known_reg, act_reg;
    logic [31:0] rate_reg, burst_reg, tok_reg;
    logic [47:0] last_reg;
    logic [QCNT_W-1:0] qc_reg;
    logic [QIDX_W-1:0] qh_reg;
    logic [15:0] qrd_reg;
    logic [79:0] prod_reg;
    logic [2:0]  action_reg;
    logic [1:0]  status_reg;
    logic        wake_reg, need_div_reg, need_head_reg, zero_rate_reg;
    logic [47:0] delay_reg;

    // divider: ceil((diff<<16) / rate), restoring, one bit per cycle
    logic [47:0] dividend_reg;
    logic [47:0] quo_reg;
    logic [32:0] rem_reg;
    logic [5:0]  dcnt_reg;

    logic [FLOW_W-1:0] f;
    assign f = it_reg.flow;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qlimit_reg  <= 7'd64;
            minrate_reg <= 32'd1;
        end
        else if (cfg_we)
        begin
            if (cfg_idx == CFG_QUEUE_LIMIT)
                qlimit_reg <= cfg_data[6:0];
            else if (cfg_idx == CFG_MIN_RATE)
                minrate_reg <= cfg_data;
        end
    end

    // refill arithmetic; the product is built from two 24-bit halves of elapsed
    logic [47:0] elapsed;
    logic [23:0] mul_a;
    logic [55:0] part;
    logic [80:0] total;
    logic [64:0] fill;
    logic [31:0] refilled;
    assign elapsed = (it_reg.now >= last_reg) ? it_reg.now - last_reg : 48'd0;
    assign mul_a = ctl.mul_acc ? elapsed[47:24] : elapsed[23:0];
    assign part = {32'd0, mul_a} * {24'd0, rate_reg};
    assign total = {33'd0, tok_reg, 16'd0} + {1'b0, prod_reg} + 81'h8000;
    assign fill = total[80:16];
    // a product past 48 bits fills the bucket
    assign refilled = (prod_reg[79:48] != '0 || fill > {33'd0, burst_reg}) ?
                      burst_reg : fill[31:0];

    logic [31:0] clamped;
    assign clamped = (it_reg.rate < minrate_reg) ? minrate_reg : it_reg.rate;

    logic [6:0] lim;
    assign lim = (qlimit_reg < 7'(QUEUE_DEPTH)) ? qlimit_reg : 7'(QUEUE_DEPTH);

    logic [18:0] bits;
    assign bits = {it_reg.size_bytes, 3'd0};
    logic [18:0] hbits;
    assign hbits = {qrd_reg, 3'd0};
    logic [18:0] div_bits;
    assign div_bits = need_head_reg ? hbits : bits;

    logic [QIDX_W-1:0] slot;
    assign slot = qh_reg + qc_reg[QIDX_W-1:0];

    logic [33:0] rem_sh, rem_sub;
    assign rem_sh = {rem_reg, dividend_reg[47]};
    assign rem_sub = rem_sh - {2'd0, rate_reg};

    assign sts.need_refill = known_reg && (it_reg.command == CMD_RESUME
        ? qc_reg != '0 : (it_reg.command == CMD_PACKET && act_reg && qc_reg == '0));
    // next head after a release on an active flow: divide only when it does not fit
    assign sts.need_div = need_div_reg ||
        (need_head_reg && act_reg && {13'd0, hbits} > tok_reg);
    assign sts.need_head = need_head_reg;
    assign sts.div_done = (dcnt_reg == 6'd0);

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            it_reg    <= in_item;
            known_reg <= exists_reg[in_item.flow];
            act_reg   <= active_reg[in_item.flow];
            rate_reg  <= rate_mem[in_item.flow];
            burst_reg <= burst_mem[in_item.flow];
            tok_reg   <= tok_mem[in_item.flow];
            last_reg  <= last_mem[in_item.flow];
            qc_reg    <= qcnt_reg[in_item.flow];
            qh_reg    <= qhead_reg[in_item.flow];
            qrd_reg   <= qmem[{in_item.flow, qhead_reg[in_item.flow]}];
            need_div_reg  <= 1'b0;
            need_head_reg <= 1'b0;
            wake_reg      <= 1'b0;
            delay_reg     <= '0;
        end
        if (ctl.mul_go)
            prod_reg <= {24'd0, part};
        if (ctl.mul_acc)
            prod_reg <= prod_reg + {part, 24'd0};
        if (ctl.refill)
        begin
            tok_reg  <= refilled;
            last_reg <= it_reg.now;
        end
        if (ctl.head_read)
            qrd_reg <= qmem[{f, qh_reg}];
        if (ctl.div_go)
        begin
            dividend_reg <= {13'd0, div_bits - tok_reg[18:0], 16'd0};
            rem_reg  <= '0;
            quo_reg  <= '0;
            dcnt_reg <= 6'(DIV_STEPS);
            zero_rate_reg <= (rate_reg == 0);
        end
        if (ctl.div_step && dcnt_reg != 0)
        begin
            dividend_reg <= {dividend_reg[46:0], 1'b0};
            if (!rem_sub[33])
            begin
                rem_reg <= rem_sub[32:0];
                quo_reg <= {quo_reg[46:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh[32:0];
                quo_reg <= {quo_reg[46:0], 1'b0};
            end
            dcnt_reg <= dcnt_reg - 6'd1;
        end
        if (ctl.div_step && dcnt_reg == 6'd1)
        begin
            delay_reg <= zero_rate_reg ? 48'hFFFF_FFFF_FFFF :
                {quo_reg[46:0], !rem_sub[33]} +
                48'((rem_sub[33] ? rem_sh[32:0] : rem_sub[32:0]) != 0);
        end
        if (ctl.decide)
        begin
            action_reg <= ACT_NONE;
            status_reg <= ST_OK;
            if (it_reg.command <= CMD_DEACTIVATE && !known_reg)
            begin
                status_reg <= (it_reg.command == CMD_ACTIVATE) ? ST_OK : ST_UNKNOWN;
                if (it_reg.command == CMD_PACKET)
                    action_reg <= ACT_PASS;
            end
            else if (it_reg.command == CMD_PACKET)
            begin
                if (!act_reg)
                    action_reg <= ACT_PASS;
                else if (qc_reg == '0 && {13'd0, bits} <= tok_reg)
                begin
                    action_reg <= ACT_SENT;
                    tok_reg    <= tok_reg - {13'd0, bits};
                end
                else if (qc_reg >= lim)
                    action_reg <= ACT_DROPPED;
                else
                begin
                    action_reg <= ACT_QUEUED;
                    if (qc_reg == '0)
                    begin
                        wake_reg <= 1'b1;
                        need_div_reg <= 1'b1;
                    end
                end
            end
            else if (it_reg.command == CMD_RESUME)
            begin
                if (qc_reg == '0)
                    status_reg <= ST_EMPTY;
                else
                begin
                    action_reg <= ACT_RELEASED;
                    qh_reg <= qh_reg + QIDX_W'(1);
                    qc_reg <= qc_reg - QCNT_W'(1);
                    if ({13'd0, hbits} <= tok_reg)
                        tok_reg <= tok_reg - {13'd0, hbits};
                    if (qc_reg > QCNT_W'(1))
                    begin
                        wake_reg <= 1'b1;
                        need_head_reg <= 1'b1;
                    end
                end
            end
        end
    end

    logic do_q;
    assign do_q = ctl.finish && action_reg == ACT_QUEUED;

    always_ff @(posedge clk)
    begin
        if (do_q)
            qmem[{f, slot}] <= it_reg.size_bytes;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.finish && known_reg)
        begin
            tok_mem[f]  <= tok_reg;
            last_mem[f] <= last_reg;
        end
        if (ctl.finish && it_reg.command == CMD_ACTIVATE && (!known_reg || !act_reg))
        begin
            rate_mem[f]  <= clamped;
            burst_mem[f] <= it_reg.burst;
            tok_mem[f]   <= it_reg.burst;
            last_mem[f]  <= '0;
        end
        if (ctl.finish && known_reg && it_reg.command == CMD_MODIFY)
        begin
            rate_mem[f]  <= clamped;
            burst_mem[f] <= it_reg.burst;
            tok_mem[f]   <= (tok_reg > it_reg.burst) ? it_reg.burst : tok_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exists_reg <= '0;
            active_reg <= '0;
            for (int i = 0; i < NUM_FLOWS; i++)
            begin
                qcnt_reg[i]  <= '0;
                qhead_reg[i] <= '0;
            end
            for (int i = 0; i < 4; i++)
                cnt_reg[i] <= '0;
            res.action         <= ACT_NONE;
            res.wake_valid     <= 1'b0;
            res.wake_delay     <= '0;
            res.status         <= ST_OK;
            res.received_count <= '0;
            res.sent_count     <= '0;
            res.shaped_count   <= '0;
            res.dropped_count  <= '0;
        end
        else if (ctl.finish)
        begin
            res.action     <= action_reg;
            res.wake_valid <= wake_reg;
            res.wake_delay <= wake_reg ? delay_reg : 48'd0;
            res.status     <= status_reg;
            if (it_reg.command == CMD_ACTIVATE && !known_reg)
            begin
                exists_reg[f] <= 1'b1;
                active_reg[f] <= 1'b1;
                qcnt_reg[f]   <= '0;
                qhead_reg[f]  <= '0;
            end
            else if (known_reg && it_reg.command == CMD_ACTIVATE)
                active_reg[f] <= 1'b1;
            else if (known_reg && it_reg.command == CMD_DEACTIVATE)
                active_reg[f] <= 1'b0;
            if (action_reg == ACT_QUEUED)
                qcnt_reg[f] <= qc_reg + QCNT_W'(1);
            if (action_reg == ACT_RELEASED)
            begin
                qcnt_reg[f]  <= qc_reg;
                qhead_reg[f] <= qh_reg;
            end
            if (it_reg.command == CMD_CLEAR_CNT)
            begin
                for (int i = 0; i < 4; i++)
                    cnt_reg[i] <= '0;
                res.received_count <= '0;
                res.sent_count     <= '0;
                res.shaped_count   <= '0;
                res.dropped_count  <= '0;
            end
            else
            begin
                if (known_reg && it_reg.command == CMD_PACKET && act_reg)
                begin
                    cnt_reg[0] <= cnt_reg[0] + 1;
                    res.received_count <= cnt_reg[0] + 1;
                end
                else
                    res.received_count <= cnt_reg[0];
                if (action_reg == ACT_SENT || action_reg == ACT_RELEASED)
                begin
                    cnt_reg[1] <= cnt_reg[1] + 1;
                    res.sent_count <= cnt_reg[1] + 1;
                end
                else
                    res.sent_count <= cnt_reg[1];
                if (action_reg == ACT_QUEUED)
                begin
                    cnt_reg[2] <= cnt_reg[2] + 1;
                    res.shaped_count <= cnt_reg[2] + 1;
                end
                else
                    res.shaped_count <= cnt_reg[2];
                if (action_reg == ACT_DROPPED)
                begin
                    cnt_reg[3] <= cnt_reg[3] + 1;
                    res.dropped_count <= cnt_reg[3] + 1;
                end
                else
                    res.dropped_count <= cnt_reg[3];
            end
        end
    end

endmodule

// ===== hw/rtl/pfts_checker.sv =====
`timescale 1ns / 1ps

module pfts_checker
    import pfts_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input logic      out_valid,
    input logic      out_ready,
    input out_item_t out_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result beat changed while stalled");

    a_no_wake_delay: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.wake_valid |-> out_data.wake_delay == 48'd0)
        else $error("delay without wake");

    a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second beat accepted while busy");

endmodule

bind per_flow_token_bucket_shaper pfts_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
